[hdl/byte_ring_fifo_unit_assert.svh]
// Assertion macros for the byte ring FIFO.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef BYTE_RING_FIFO_UNIT_ASSERT_SVH
`define BYTE_RING_FIFO_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The antecedent implies the consequent at the same edge.
`define BRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[hdl/brf_pkg.sv]
// Shared constants and types for the byte ring FIFO.
// No dependencies.
package brf_pkg;

  localparam int unsigned DataW      = 8;
  localparam int unsigned CmdW       = 3;
  localparam int unsigned SizeW      = 7;
  localparam int unsigned AmountW    = 7;
  localparam int unsigned LevelW     = 7;
  localparam int unsigned DepthDef   = 64;
  localparam logic [SizeW-1:0] SizeReset = 7'd64;

  // Command codes carried by cmd_i.
  typedef enum logic [CmdW-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_DROP  = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  // Sequencer states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

endpackage

[hdl/byte_ring_fifo_unit.sv]
// Top level of the byte ring FIFO: command decode, pointers and storage.
// Depends on brf_pkg and byte_ring_fifo_unit_assert.svh.
//
// Usage: commands enter on the in channel (valid/ready) and results leave on
// the out channel (valid/ready); each beat carries one result. Push, drop,
// clear and refused commands give one result, registered in the cycle after
// the command is accepted. Pop gives one byte, which passes through the
// registered read port of the storage memory and then the output register.
// Peek of k bytes gives its first byte by the same path and then one byte
// per cycle while the receiver is ready, paced by the memory's single read port.
// Push, drop and clear sustain one command per cycle while the receiver is
// ready; pop and peek hold off new commands until their last byte is registered.
// A new command is taken while the previous result sits in the output
// register, as long as that register is taken in the same cycle.
// When the receiver stalls, the output register holds its beat and a peek
// in progress waits with its next byte already read.
// Reset empties the FIFO and sets size_in_use to 64; the storage contents
// are not cleared, as only written entries are ever read. A write on the
// configuration port sets the size and also empties the FIFO.
module byte_ring_fifo_unit #(
  parameter int unsigned DEPTH = brf_pkg::DepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [brf_pkg::SizeW-1:0]  size_in_use_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [brf_pkg::CmdW-1:0]   cmd_i,
  input  logic [brf_pkg::DataW-1:0]  data_in_i,
  input  logic [brf_pkg::AmountW-1:0] amount_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [brf_pkg::DataW-1:0]  data_out_o,
  output logic                       data_valid_o,
  output logic                       ok_o,
  output logic                       last_o,
  output logic [brf_pkg::LevelW-1:0] level_o,
  output logic                       is_full_o,
  output logic                       is_empty_o
);
  import brf_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Wrapping increment of a pointer within the effective size.
  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p,
                                              input logic [CntW-1:0] sz);
    logic [CntW-1:0] nxt;
    nxt = CntW'(p) + CntW'(1);
    if (nxt == sz) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = nxt[PtrW-1:0];
    end
  endfunction

  // Control registers.
  state_e            state_q, state_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [CntW-1:0]   level_q, level_d;
  logic [PtrW-1:0]   peek_ptr_q, peek_ptr_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;

  // Output payload registers.
  logic [DataW-1:0]  out_data_q, out_data_d;
  logic              out_dvalid_q, out_dvalid_d;
  logic              out_ok_q, out_ok_d;
  logic              out_last_q, out_last_d;
  logic [CntW-1:0]   out_level_q, out_level_d;
  logic              out_full_q, out_full_d;
  logic              out_empty_q, out_empty_d;

  // Storage memory and its port controls.
  logic [DataW-1:0]  mem_q [DEPTH];
  logic [DataW-1:0]  rd_data_q;
  logic              mem_we, mem_re;
  logic [PtrW-1:0]   mem_raddr;

  // Combinational helpers.
  logic [CntW-1:0]   sz_eff;
  logic              in_acc;
  logic              out_free;
  logic [LevelW-1:0] level_ext;
  logic [CntW-1:0]   len;
  logic [CntW:0]     drop_sum;

  // Effective size: zero acts as one, above DEPTH acts as DEPTH.
  always_comb begin
    if (size_q == '0) begin
      sz_eff = CntW'(1);
    end else if (size_q > SizeW'(DEPTH)) begin
      sz_eff = CntW'(DEPTH);
    end else begin
      sz_eff = size_q[CntW-1:0];
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_acc     = in_valid_i && in_ready_o;

  // Clamped run length for peek and drop, and the drop pointer sum.
  assign level_ext = LevelW'(level_q);
  assign len       = (amount_i < level_ext) ? amount_i[CntW-1:0] : level_q;
  assign drop_sum  = (CntW+1)'(rd_ptr_q) + (CntW+1)'(len);

  // Command decode and read sequencing.
  always_comb begin
    state_d      = state_q;
    size_d       = size_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    level_d      = level_q;
    peek_ptr_d   = peek_ptr_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_data_d   = out_data_q;
    out_dvalid_d = out_dvalid_q;
    out_ok_d     = out_ok_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          // Default beat: refused, no data.
          out_valid_d  = 1'b1;
          out_data_d   = '0;
          out_dvalid_d = 1'b0;
          out_ok_d     = 1'b0;
          out_last_d   = 1'b1;
          case (cmd_i)
            CMD_PUSH: begin
              if (level_q < sz_eff) begin
                mem_we   = 1'b1;
                wr_ptr_d = ptr_inc(wr_ptr_q, sz_eff);
                level_d  = level_q + CntW'(1);
                out_ok_d = 1'b1;
              end
            end
            CMD_POP: begin
              if (level_q != '0) begin
                mem_re      = 1'b1;
                rd_ptr_d    = ptr_inc(rd_ptr_q, sz_eff);
                level_d     = level_q - CntW'(1);
                cnt_d       = CntW'(1);
                out_valid_d = 1'b0;
                state_d     = S_READ;
              end
            end
            CMD_PEEK: begin
              if (level_q != '0) begin
                if (len == '0) begin
                  out_ok_d = 1'b1;
                end else begin
                  mem_re      = 1'b1;
                  peek_ptr_d  = ptr_inc(rd_ptr_q, sz_eff);
                  cnt_d       = len;
                  out_valid_d = 1'b0;
                  state_d     = S_READ;
                end
              end
            end
            CMD_DROP: begin
              if (level_q != '0) begin
                if (drop_sum >= (CntW+1)'(sz_eff)) begin
                  rd_ptr_d = PtrW'(drop_sum - (CntW+1)'(sz_eff));
                end else begin
                  rd_ptr_d = drop_sum[PtrW-1:0];
                end
                level_d  = level_q - len;
                out_ok_d = 1'b1;
              end
            end
            CMD_CLEAR: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              level_d  = '0;
              out_ok_d = 1'b1;
            end
            default: begin
              out_ok_d = 1'b0;
            end
          endcase
        end
      end
      S_READ: begin
        // The byte held in the read register moves into the output register once free.
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_data_d   = rd_data_q;
          out_dvalid_d = 1'b1;
          out_ok_d     = 1'b1;
          out_last_d   = (cnt_q == CntW'(1));
          cnt_d        = cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_d = S_IDLE;
          end else begin
            mem_re     = 1'b1;
            mem_raddr  = peek_ptr_q;
            peek_ptr_d = ptr_inc(peek_ptr_q, sz_eff);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A size write empties the FIFO; the user must send it only while idle, as the block does not enforce this.
    if (cfg_we_i) begin
      size_d   = size_in_use_i;
      rd_ptr_d = '0;
      wr_ptr_d = '0;
      level_d  = '0;
    end
  end

  // Status fields always reflect the level after the command.
  always_comb begin
    if (state_q == S_READ) begin
      out_level_d = level_q;
    end else begin
      out_level_d = level_d;
    end
    out_full_d  = (out_level_d == sz_eff);
    out_empty_d = (out_level_d == '0);
    if (!(out_valid_d && !(out_valid_q && !out_ready_i))) begin
      out_level_d = out_level_q;
      out_full_d  = out_full_q;
      out_empty_d = out_empty_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= SizeReset;
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      level_q     <= '0;
      peek_ptr_q  <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_ptr_q    <= wr_ptr_d;
      level_q     <= level_d;
      peek_ptr_q  <= peek_ptr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload, no reset needed.
  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_dvalid_q <= out_dvalid_d;
    out_ok_q     <= out_ok_d;
    out_last_q   <= out_last_d;
    out_level_q  <= out_level_d;
    out_full_q   <= out_full_d;
    out_empty_q  <= out_empty_d;
  end

  // Storage memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_ptr_q] <= data_in_i;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = out_data_q;
  assign data_valid_o = out_dvalid_q;
  assign ok_o         = out_ok_q;
  assign last_o       = out_last_q;
  assign level_o      = LevelW'(out_level_q);
  assign is_full_o    = out_full_q;
  assign is_empty_o   = out_empty_q;

  // Checks on pointer and sequencer consistency.
`include "byte_ring_fifo_unit_assert.svh"

  `BRF_ASSERT(a_level_in_range, level_q <= sz_eff, "level exceeds size in use")
  `BRF_ASSERT(a_rd_ptr_in_range, CntW'(rd_ptr_q) < sz_eff, "read pointer beyond size")
  `BRF_ASSERT(a_wr_ptr_in_range, CntW'(wr_ptr_q) < sz_eff, "write pointer beyond size")
  `BRF_ASSERT_IMP(a_read_has_count, state_q == S_READ, cnt_q != '0, "read state with no bytes left")

endmodule
